### design/lrutt_pkg.sv
// ----------------------------------------------------------------------------
// lrutt_pkg
// Shared constants, codes and controller/datapath handshake types for the
// LRU tracking table.
// ----------------------------------------------------------------------------
package lrutt_pkg;

  // Number of table slots (1 to 16)
  localparam int SLOTS   = 2;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 28;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // latch input item, clear scan state
    logic scan_step;  // examine one slot
    logic commit;     // update table, load result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_lookup;  // item on the input is a lookup
    logic scan_last;  // current scan slot is the last one
    logic out_free;   // result register can take a new result
  } status_t;

endpackage

### design/lrutt_in_if.sv
// ----------------------------------------------------------------------------
// lrutt_in_if
// Request channel of the LRU tracking table.
// ----------------------------------------------------------------------------
interface lrutt_in_if;
  logic                          valid;
  logic                          ready;
  logic [lrutt_pkg::OP_W-1:0]    op;
  logic [lrutt_pkg::KEY_W-1:0]   key;
  logic [lrutt_pkg::STAMP_W-1:0] now;
  logic [lrutt_pkg::SLOT_W-1:0]  slot_sel;

  modport source (output valid, op, key, now, slot_sel, input ready);
  modport sink   (input valid, op, key, now, slot_sel, output ready);
endinterface

### design/lrutt_out_if.sv
// ----------------------------------------------------------------------------
// lrutt_out_if
// Result channel of the LRU tracking table.
// ----------------------------------------------------------------------------
interface lrutt_out_if;
  logic                          valid;
  logic                          ready;
  logic [lrutt_pkg::SLOT_W-1:0]  slot;
  logic                          hit;
  logic                          evicted;
  logic                          entry_valid;
  logic [lrutt_pkg::KEY_W-1:0]   key_out;
  logic [lrutt_pkg::STAMP_W-1:0] stamp_out;

  modport source (output valid, slot, hit, evicted, entry_valid, key_out, stamp_out,
                  input ready);
  modport sink   (input valid, slot, hit, evicted, entry_valid, key_out, stamp_out,
                  output ready);
endinterface

### design/lrutt_ctrl.sv
// ----------------------------------------------------------------------------
// lrutt_ctrl
// Sequencer: accepts an item, walks the slot scan for lookups, then commits
// the table update and result once the result register is free.
// ----------------------------------------------------------------------------
module lrutt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lrutt_pkg::status_t status_i,
  output lrutt_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_lookup ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/lrutt_dpath.sv
// ----------------------------------------------------------------------------
// lrutt_dpath
// Slot storage, one-slot-per-cycle scan for hit / free / oldest, table update
// and the result register.
// ----------------------------------------------------------------------------
module lrutt_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrutt_pkg::cmd_t     cmd_i,
  output lrutt_pkg::status_t  status_o,
  lrutt_in_if.sink            in_i,
  lrutt_out_if.source         out_o
);

  localparam int AW = lrutt_pkg::SLOT_AW;

  // Table storage
  logic [lrutt_pkg::SLOTS-1:0]   valid_q;
  logic [lrutt_pkg::KEY_W-1:0]   key_mem   [lrutt_pkg::SLOTS];
  logic [lrutt_pkg::STAMP_W-1:0] stamp_mem [lrutt_pkg::SLOTS];

  // Latched item
  logic [lrutt_pkg::OP_W-1:0]    op_q;
  logic [lrutt_pkg::KEY_W-1:0]   key_q;
  logic [lrutt_pkg::STAMP_W-1:0] now_q;
  logic [lrutt_pkg::SLOT_W-1:0]  sel_q;

  // Scan state
  logic [AW-1:0]                 cnt_q;
  logic                          found_q;
  logic [AW-1:0]                 hit_idx_q;
  logic                          has_free_q;
  logic [AW-1:0]                 free_idx_q;
  logic [lrutt_pkg::STAMP_W-1:0] oldest_q;
  logic [AW-1:0]                 old_idx_q;

  // Result register
  logic                          out_valid_q;
  logic [lrutt_pkg::SLOT_W-1:0]  r_slot_q,  r_slot_d;
  logic                          r_hit_q,   r_hit_d;
  logic                          r_evict_q, r_evict_d;
  logic                          r_valid_q, r_valid_d;
  logic [lrutt_pkg::KEY_W-1:0]   r_key_q,   r_key_d;
  logic [lrutt_pkg::STAMP_W-1:0] r_stamp_q, r_stamp_d;

  logic [AW-1:0]                 rd_addr;
  logic                          rd_valid;
  logic [lrutt_pkg::KEY_W-1:0]   rd_key;
  logic [lrutt_pkg::STAMP_W-1:0] rd_stamp;
  logic                          sel_in_range;
  logic [AW-1:0]                 sel_idx;
  logic [AW-1:0]                 pick;
  logic                          evict;

  assign sel_in_range = ({1'b0, sel_q} < (lrutt_pkg::SLOT_W + 1)'(lrutt_pkg::SLOTS));
  assign sel_idx      = sel_q[AW-1:0];

  // Single read port: scan slot during the walk, addressed slot otherwise
  assign rd_addr  = cmd_i.scan_step ? cnt_q : sel_idx;
  assign rd_valid = valid_q[rd_addr];
  assign rd_key   = key_mem[rd_addr];
  assign rd_stamp = stamp_mem[rd_addr];

  assign evict = !found_q && !has_free_q;
  assign pick  = found_q ? hit_idx_q : (has_free_q ? free_idx_q : old_idx_q);

  assign status_o.in_lookup = (in_i.op == lrutt_pkg::OP_LOOKUP);
  assign status_o.scan_last = (cnt_q == AW'(lrutt_pkg::SLOTS - 1));
  assign status_o.out_free  = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= in_i.op;
      key_q      <= in_i.key;
      now_q      <= in_i.now;
      sel_q      <= in_i.slot_sel;
      cnt_q      <= '0;
      found_q    <= 1'b0;
      hit_idx_q  <= '0;
      has_free_q <= 1'b0;
      free_idx_q <= '0;
      oldest_q   <= '1;
      old_idx_q  <= '0;
    end else if (cmd_i.scan_step) begin
      cnt_q <= cnt_q + AW'(1);
      if (rd_valid && (rd_key == key_q) && !found_q) begin
        found_q   <= 1'b1;
        hit_idx_q <= cnt_q;
      end
      if (!rd_valid) begin
        if (!has_free_q) begin
          has_free_q <= 1'b1;
          free_idx_q <= cnt_q;
        end
      end else if (rd_stamp < oldest_q) begin
        oldest_q  <= rd_stamp;
        old_idx_q <= cnt_q;
      end
    end
  end

  // Key and stamp storage: only read for live slots, so no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (op_q == lrutt_pkg::OP_LOOKUP)) begin
      key_mem[pick]   <= key_q;
      stamp_mem[pick] <= now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.commit) begin
      if (op_q == lrutt_pkg::OP_LOOKUP) begin
        valid_q[pick] <= 1'b1;
      end else if ((op_q == lrutt_pkg::OP_DELETE) && sel_in_range) begin
        valid_q[sel_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    r_slot_d  = '0;
    r_hit_d   = 1'b0;
    r_evict_d = 1'b0;
    r_valid_d = 1'b0;
    r_key_d   = '0;
    r_stamp_d = '0;
    case (op_q)
      lrutt_pkg::OP_LOOKUP: begin
        r_slot_d  = lrutt_pkg::SLOT_W'(pick);
        r_hit_d   = found_q;
        r_evict_d = evict;
        r_valid_d = 1'b1;
        r_key_d   = key_q;
        r_stamp_d = now_q;
      end
      lrutt_pkg::OP_DELETE: begin
        r_slot_d = sel_q;
      end
      lrutt_pkg::OP_READ: begin
        r_slot_d = sel_q;
        if (sel_in_range && rd_valid) begin
          r_valid_d = 1'b1;
          r_key_d   = rd_key;
          r_stamp_d = rd_stamp;
        end
      end
      default: begin
        r_slot_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      r_slot_q  <= r_slot_d;
      r_hit_q   <= r_hit_d;
      r_evict_q <= r_evict_d;
      r_valid_q <= r_valid_d;
      r_key_q   <= r_key_d;
      r_stamp_q <= r_stamp_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.slot        = r_slot_q;
  assign out_o.hit         = r_hit_q;
  assign out_o.evicted     = r_evict_q;
  assign out_o.entry_valid = r_valid_q;
  assign out_o.key_out     = r_key_q;
  assign out_o.stamp_out   = r_stamp_q;

endmodule

### design/lru_tracking_table.sv
// ----------------------------------------------------------------------------
// lru_tracking_table
// Small associative table of tracked transmitters with LRU slot reuse.
// ----------------------------------------------------------------------------
// One item at a time. A lookup (op 0) walks the slots one per cycle, checking
// for a key hit, the first free slot and the oldest stamp, then commits its
// table update and result. Delete, read and the undefined op skip the walk and
// go straight to the commit. Results sit in an output register, and the next
// item is accepted while a result waits to be taken; a further result, and with
// it the following accept, is held back until the register drains. Slot valid
// bits clear at reset; keys and stamps are only read for live slots.
module lru_tracking_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  lrutt_in_if.sink    in_i,
  lrutt_out_if.source out_o
);

  lrutt_pkg::cmd_t    cmd;
  lrutt_pkg::status_t status;

  lrutt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lrutt_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .in_i     (in_i),
    .out_o    (out_o)
  );

  // Only one item in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("item accepted while previous still in progress");

  // A hit never evicts and always reports a live entry
  a_hit_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.hit) |-> (out_o.entry_valid && !out_o.evicted))
    else $error("hit result inconsistent");

  // Dead entries report zero key and stamp
  a_dead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.entry_valid) |->
      ((out_o.key_out == '0) && (out_o.stamp_out == '0) && !out_o.hit && !out_o.evicted))
    else $error("dead entry carries data");

  // Live entries always name an existing slot
  a_live_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.entry_valid) |->
      ({1'b0, out_o.slot} < (lrutt_pkg::SLOT_W + 1)'(lrutt_pkg::SLOTS)))
    else $error("live entry outside slot range");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU tracking table. A local copy of the slot
// table predicts each result when the item is accepted; the result checker
// pops those predictions in order and compares every field. Directed items
// hit the corner cases (all-ones stamps, ties, out-of-range slots, free slot
// reads, undefined op), then random mixes run with and without idle bursts,
// a long result-side hold-off and a sender pause.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 200;
  localparam int KEY_POOL_N     = lrutt_pkg::SLOTS + 3;

  typedef struct {
    logic [lrutt_pkg::SLOT_W-1:0]  slot;
    logic                          hit;
    logic                          evicted;
    logic                          entry_valid;
    logic [lrutt_pkg::KEY_W-1:0]   key;
    logic [lrutt_pkg::STAMP_W-1:0] stamp;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lrutt_in_if  req_if ();
  lrutt_out_if rsp_if ();

  lru_tracking_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predicted table contents
  logic                          tbl_live  [lrutt_pkg::SLOTS];
  logic [lrutt_pkg::KEY_W-1:0]   tbl_key   [lrutt_pkg::SLOTS];
  logic [lrutt_pkg::STAMP_W-1:0] tbl_stamp [lrutt_pkg::SLOTS];

  table_result_t                 expected_q[$];
  logic [lrutt_pkg::KEY_W-1:0]   key_pool [KEY_POOL_N];
  logic [lrutt_pkg::STAMP_W-1:0] stamp_base;
  bit                            idle_en;
  bit                            hold_req;
  int                            errors;

  // Applies one item to the predicted table and returns its result.
  function automatic table_result_t table_apply(lrutt_pkg::op_e op,
                                                logic [lrutt_pkg::KEY_W-1:0] key,
                                                logic [lrutt_pkg::STAMP_W-1:0] now,
                                                logic [lrutt_pkg::SLOT_W-1:0] sel);
    table_result_t                 r;
    bit                            found;
    bit                            has_free;
    int                            pick;
    int                            free_idx;
    int                            old_idx;
    logic [lrutt_pkg::STAMP_W-1:0] oldest;
    r = '{default: '0};
    found = 1'b0;
    has_free = 1'b0;
    pick = 0;
    free_idx = 0;
    old_idx = 0;
    oldest = '1;
    case (op)
      lrutt_pkg::OP_LOOKUP: begin
        for (int i = 0; i < lrutt_pkg::SLOTS; i++) begin
          if (!found && tbl_live[i] && tbl_key[i] == key) begin
            found = 1'b1;
            pick = i;
          end
        end
        if (!found) begin
          for (int i = 0; i < lrutt_pkg::SLOTS; i++) begin
            if (!tbl_live[i]) begin
              if (!has_free) begin
                has_free = 1'b1;
                free_idx = i;
              end
            end else if (tbl_stamp[i] < oldest) begin
              oldest = tbl_stamp[i];
              old_idx = i;
            end
          end
          pick = has_free ? free_idx : old_idx;
          r.evicted = !has_free;
          tbl_live[pick] = 1'b1;
          tbl_key[pick] = key;
        end
        tbl_stamp[pick] = now;
        r.slot = lrutt_pkg::SLOT_W'(pick);
        r.hit = found;
        r.entry_valid = 1'b1;
        r.key = key;
        r.stamp = now;
      end
      lrutt_pkg::OP_DELETE, lrutt_pkg::OP_READ: begin
        r.slot = sel;
        if (int'(sel) < lrutt_pkg::SLOTS) begin
          if (op == lrutt_pkg::OP_DELETE) begin
            tbl_live[sel] = 1'b0;
          end else if (tbl_live[sel]) begin
            r.entry_valid = 1'b1;
            r.key = tbl_key[sel];
            r.stamp = tbl_stamp[sel];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic check_result();
    table_result_t exp;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, slot %0d key 0x%0h", $time, rsp_if.slot,
               rsp_if.key_out);
      errors++;
    end else begin
      exp = expected_q.pop_front();
      check_field("slot", 32'(exp.slot), 32'(rsp_if.slot));
      check_field("hit", 32'(exp.hit), 32'(rsp_if.hit));
      check_field("evicted", 32'(exp.evicted), 32'(rsp_if.evicted));
      check_field("entry_valid", 32'(exp.entry_valid), 32'(rsp_if.entry_valid));
      check_field("key_out", 32'(exp.key), 32'(rsp_if.key_out));
      check_field("stamp_out", exp.stamp, rsp_if.stamp_out);
    end
  endtask

  // Result side: check each accepted item, then pick next cycle's ready.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) check_result();
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        rsp_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** lru_tracking_table: FAILED **");
    $finish;
  end

  // Valid stays high after an accept so back-to-back items need no extra
  // edge on it; callers drop it with stop_req before any wait.
  task automatic send_req(input lrutt_pkg::op_e op,
                          input logic [lrutt_pkg::KEY_W-1:0] key,
                          input logic [lrutt_pkg::STAMP_W-1:0] now,
                          input logic [lrutt_pkg::SLOT_W-1:0] sel);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.op       <= op;
    req_if.key      <= key;
    req_if.now      <= now;
    req_if.slot_sel <= sel;
    do @(posedge clk_i); while (!req_if.ready);
    expected_q.push_back(table_apply(op, key, now, sel));
  endtask

  task automatic stop_req();
    req_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_req();
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Mostly a slowly rising clock so recency matters, with repeats for ties
  // and the odd wild or all-ones stamp.
  function automatic logic [lrutt_pkg::STAMP_W-1:0] next_stamp();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom;
    if (r == 1) return '1;
    stamp_base += $urandom_range(0, 3);
    return stamp_base;
  endfunction

  task automatic send_random_item();
    lrutt_pkg::op_e               op;
    logic [lrutt_pkg::KEY_W-1:0]  key;
    logic [lrutt_pkg::SLOT_W-1:0] sel;
    int                           r;
    r = $urandom_range(0, 99);
    if (r < 60)      op = lrutt_pkg::OP_LOOKUP;
    else if (r < 80) op = lrutt_pkg::OP_READ;
    else if (r < 96) op = lrutt_pkg::OP_DELETE;
    else             op = lrutt_pkg::OP_NONE;
    // A small key pool keeps hits and evictions frequent
    if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    else                          key = lrutt_pkg::KEY_W'($urandom);
    if ($urandom_range(0, 9) < 8)
      sel = lrutt_pkg::SLOT_W'($urandom_range(0, lrutt_pkg::SLOTS - 1));
    else
      sel = lrutt_pkg::SLOT_W'($urandom_range(0, 15));
    send_req(op, key, next_stamp(), sel);
  endtask

  task automatic test_directed();
    send_req(lrutt_pkg::OP_READ, '0, '0, 4'd0);            // free slot read
    send_req(lrutt_pkg::OP_READ, '1, '1, 4'd15);           // slot out of range
    send_req(lrutt_pkg::OP_DELETE, '0, '0, 4'd1);          // delete of a free slot
    send_req(lrutt_pkg::OP_NONE, '1, '1, 4'd15);
    send_req(lrutt_pkg::OP_LOOKUP, '0, '0, 4'd0);
    send_req(lrutt_pkg::OP_LOOKUP, '1, '1, 4'd0);
    send_req(lrutt_pkg::OP_READ, '0, '0, 4'd1);
    send_req(lrutt_pkg::OP_LOOKUP, '0, 32'd5, 4'd15);      // hit, refresh
    send_req(lrutt_pkg::OP_LOOKUP, 28'd123, 32'd7, 4'd0);  // evict oldest
    send_req(lrutt_pkg::OP_LOOKUP, '1, '1, 4'd0);
    send_req(lrutt_pkg::OP_LOOKUP, 28'd123, '1, 4'd0);
    // every stamp all ones: reuse falls to slot 0
    send_req(lrutt_pkg::OP_LOOKUP, 28'h5A5A5A5, 32'd9, 4'd0);
    send_req(lrutt_pkg::OP_LOOKUP, '1, 32'd9, 4'd0);
    // equal stamps: lowest index wins
    send_req(lrutt_pkg::OP_LOOKUP, 28'hA5A5A5A, 32'd20, 4'd0);
    send_req(lrutt_pkg::OP_DELETE, '0, '0, 4'd0);
    send_req(lrutt_pkg::OP_READ, '0, '0, 4'd0);            // read after delete
    send_req(lrutt_pkg::OP_DELETE, '1, '1, 4'd2);
    send_req(lrutt_pkg::OP_DELETE, '0, '0, 4'd15);
    send_req(lrutt_pkg::OP_LOOKUP, 28'd77, 32'd30, 4'd0);  // takes the free slot
    send_req(lrutt_pkg::OP_READ, '0, '0, 4'd0);
    send_req(lrutt_pkg::OP_READ, '0, '0, 4'd1);
    send_req(lrutt_pkg::OP_DELETE, '0, '0, 4'd1);
    send_req(lrutt_pkg::OP_DELETE, '0, '0, 4'd0);
    send_req(lrutt_pkg::OP_LOOKUP, 28'd1, 32'd1, 4'd0);
    wait_drained();
  endtask

  task automatic test_random_mix(input int n);
    for (int i = 0; i < n; i++) send_random_item();
    wait_drained();
  endtask

  // Result side holds off while items keep coming, so the input stalls.
  task automatic test_output_stall();
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_random_item();
    wait_drained();
  endtask

  task automatic test_sender_pause();
    for (int i = 0; i < 10; i++) send_random_item();
    wait_drained();
    for (int i = 0; i < 10; i++) send_random_item();
    wait_drained();
  endtask

  initial begin
    errors     = 0;
    idle_en    = 1'b1;
    hold_req   = 1'b0;
    stamp_base = '0;
    for (int i = 0; i < lrutt_pkg::SLOTS; i++) begin
      tbl_live[i]  = 1'b0;
      tbl_key[i]   = '0;
      tbl_stamp[i] = '0;
    end
    for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = lrutt_pkg::KEY_W'($urandom);
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.op       <= lrutt_pkg::OP_NONE;
    req_if.key      <= '0;
    req_if.now      <= '0;
    req_if.slot_sel <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix(300);
    test_output_stall();
    test_sender_pause();
    idle_en = 1'b0;
    test_random_mix(200);

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("** lru_tracking_table: PASSED **");
    end else begin
      $display("** lru_tracking_table: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
design/lrutt_pkg.sv
design/lrutt_in_if.sv
design/lrutt_out_if.sv
design/lrutt_ctrl.sv
design/lrutt_dpath.sv
design/lru_tracking_table.sv
verif/tb_top.sv
